[hdl/twsrm_pkg.sv]
// ----------------------------------------------------------------------------
// Three-wire serial register master: shared types and constants
// Request codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package twsrm_pkg;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_READ   = 3'd2,
    ACT_STROBE = 3'd3,
    ACT_FSEND  = 3'd4,
    ACT_FREAD  = 3'd5,
    ACT_CLOSE  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    REG_WRITE_CMD   = 2'd0,
    REG_READ_CMD    = 2'd1,
    REG_HALF_PERIOD = 2'd2
  } reg_index_t;

  localparam int unsigned FRAME_BITS = 24;
  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned BYTE_BITS  = 8;

  localparam logic [4:0] BITS_REG  = 5'd24;
  localparam logic [4:0] BITS_BYTE = 5'd8;
  localparam logic [4:0] BITS_DATA = 5'd16;

  // One result item, as packed into the master-side tdata.
  typedef struct packed {
    logic        done_res;
    logic [15:0] read_data;
    logic        sdio_drive;
    logic        sdio_out;
    logic        serial_clock;
    logic        chip_select_n;
  } result_t;

endpackage

`default_nettype wire

[hdl/three_wire_serial_register_master_core.sv]
// ----------------------------------------------------------------------------
// Three-wire serial register master core
// Pin-level engine for a serial bus with one shared data line; each input
// transfer is one tick of the engine and yields one output transfer.
// ----------------------------------------------------------------------------
// The result of an input transfer is in the output register in the cycle after it is taken.
// Throughput: one transfer per cycle; the single output register sets this,
//   and input is taken whenever that register is empty or being drained.
// Reset (rst, synchronous, active high): engine idle, no frame open, clock low,
//   read data zero, write/read command bits zero, half period one.
`default_nettype none

module three_wire_serial_register_master_core
  import twsrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream: one engine tick per transfer
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // addr_byte[7:0], write_data[23:8], sdio_in[24], zero
  input  wire logic [2:0]  s_tuser,   // action[2:0]
  // output stream: pin levels and status for that tick
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // chip_select_n[0], serial_clock[1], sdio_out[2],
                                      // sdio_drive[3], read_data[19:4], done_res[20], zero
  // configuration write channel
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // Configuration registers
  logic [7:0] write_cmd_bits;
  logic [7:0] read_cmd_bits;
  logic [7:0] half_period;

  // Engine state
  logic                  busy;
  action_t               current_action;
  logic [FRAME_BITS-1:0] out_shift;
  logic [WORD_BITS-1:0]  in_shift;
  logic [4:0]            bits_left;
  logic [7:0]            tick_count;
  logic                  clock_level;
  logic                  frame_open;
  logic [WORD_BITS-1:0]  read_result;

  logic                  busy_next;
  action_t               current_action_next;
  logic [FRAME_BITS-1:0] out_shift_next;
  logic [WORD_BITS-1:0]  in_shift_next;
  logic [4:0]            bits_left_next;
  logic [7:0]            tick_count_next;
  logic                  clock_level_next;
  logic                  frame_open_next;
  logic [WORD_BITS-1:0]  read_result_next;

  result_t result;
  result_t result_next;

  logic       s_accept;
  action_t    action;
  logic [7:0] addr_byte;
  logic [15:0] write_data;
  logic       sdio_in;
  logic [7:0] hp_eff;
  logic [7:0] tick_inc;
  logic       released_now;
  logic       released_next;
  logic       done_next;

  // Take a new tick whenever the output register is free or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign action     = action_t'(s_tuser);
  assign addr_byte  = s_tdata[7:0];
  assign write_data = s_tdata[23:8];
  assign sdio_in    = s_tdata[24];

  // A half period of zero behaves as one.
  assign hp_eff   = (half_period == 8'd0) ? 8'd1 : half_period;
  assign tick_inc = tick_count + 8'd1;

  // The line is released for a frame read and for the data phase of a register read.
  assign released_now = busy && ((current_action == ACT_FREAD) ||
                                 (current_action == ACT_READ && bits_left <= BITS_DATA));

  always_comb begin
    busy_next           = busy;
    current_action_next = current_action;
    out_shift_next      = out_shift;
    in_shift_next       = in_shift;
    bits_left_next      = bits_left;
    tick_count_next     = tick_count;
    clock_level_next    = clock_level;
    frame_open_next     = frame_open;
    read_result_next    = read_result;
    done_next           = 1'b0;

    if (busy) begin
      tick_count_next = tick_inc;
      if (!clock_level) begin
        // Low phase: sample the line on the last low tick, then rise.
        if (tick_inc >= hp_eff) begin
          if (released_now) begin
            in_shift_next = {in_shift[WORD_BITS-2:0], sdio_in};
          end
          clock_level_next = 1'b1;
          tick_count_next  = 8'd0;
        end
      end else if (tick_inc >= hp_eff) begin
        // High phase over: fall, advance to the next bit.
        clock_level_next = 1'b0;
        tick_count_next  = 8'd0;
        out_shift_next   = {out_shift[FRAME_BITS-2:0], 1'b0};
        bits_left_next   = bits_left - 5'd1;
        if (bits_left_next == 5'd0) begin
          busy_next = 1'b0;
          done_next = 1'b1;
          case (current_action)
            ACT_READ:  read_result_next = in_shift;
            ACT_FREAD: read_result_next = {{(WORD_BITS-BYTE_BITS){1'b0}},
                                           in_shift[BYTE_BITS-1:0]};
            default:   read_result_next = read_result;
          endcase
          // A plain request ends any frame that was open.
          if (current_action == ACT_WRITE || current_action == ACT_READ ||
              current_action == ACT_STROBE) begin
            frame_open_next = 1'b0;
          end
        end
      end
    end else begin
      unique case (action) inside
        ACT_WRITE, ACT_READ, ACT_STROBE, ACT_FSEND, ACT_FREAD: begin
          busy_next           = 1'b1;
          current_action_next = action;
          in_shift_next       = '0;
          tick_count_next     = 8'd0;
          clock_level_next    = 1'b0;
          unique case (action)
            ACT_WRITE: begin
              out_shift_next = {addr_byte | write_cmd_bits, write_data};
              bits_left_next = BITS_REG;
            end
            ACT_READ: begin
              out_shift_next = {addr_byte | read_cmd_bits, 16'h0000};
              bits_left_next = BITS_REG;
            end
            ACT_STROBE: begin
              out_shift_next = {addr_byte, 16'h0000};
              bits_left_next = BITS_BYTE;
            end
            ACT_FSEND: begin
              out_shift_next  = {addr_byte, 16'h0000};
              bits_left_next  = BITS_BYTE;
              frame_open_next = 1'b1;
            end
            default: begin
              // frame read: nothing driven, line released
              out_shift_next  = '0;
              bits_left_next  = BITS_BYTE;
              frame_open_next = 1'b1;
            end
          endcase
        end
        ACT_CLOSE: begin
          frame_open_next = 1'b0;
          done_next       = 1'b1;
        end
        default: begin
          // no request, or an unused code: hold
        end
      endcase
    end

    released_next = busy_next && ((current_action_next == ACT_FREAD) ||
                                  (current_action_next == ACT_READ &&
                                   bits_left_next <= BITS_DATA));

    result_next.chip_select_n = !(busy_next || frame_open_next);
    result_next.serial_clock  = busy_next && clock_level_next;
    result_next.sdio_out      = (busy_next && !released_next) ?
                                out_shift_next[FRAME_BITS-1] : 1'b1;
    result_next.sdio_drive    = !released_next;
    result_next.read_data     = read_result_next;
    result_next.done_res      = done_next;
  end

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_cmd_bits <= 8'd0;
      read_cmd_bits  <= 8'd0;
      half_period    <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WRITE_CMD:   write_cmd_bits <= cfg_data;
        REG_READ_CMD:    read_cmd_bits  <= cfg_data;
        REG_HALF_PERIOD: half_period    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Engine state advances once per accepted input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      current_action <= ACT_NONE;
      out_shift      <= '0;
      in_shift       <= '0;
      bits_left      <= 5'd0;
      tick_count     <= 8'd0;
      clock_level    <= 1'b0;
      frame_open     <= 1'b0;
      read_result    <= '0;
    end else if (s_accept) begin
      busy           <= busy_next;
      current_action <= current_action_next;
      out_shift      <= out_shift_next;
      in_shift       <= in_shift_next;
      bits_left      <= bits_left_next;
      tick_count     <= tick_count_next;
      clock_level    <= clock_level_next;
      frame_open     <= frame_open_next;
      read_result    <= read_result_next;
    end
  end

  // Output register: hold the result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {3'b000, result};

`ifndef SYNTH
  // A finished request always leaves the serial clock low.
  a_done_clock_low: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.done_res) |-> !result.serial_clock)
    else $error("done shown with serial clock high");

  // The line is only released while select is asserted.
  a_release_selected: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.sdio_drive) |-> !result.chip_select_n)
    else $error("data line released with select high");

  // The bit counter never exceeds one full register transfer.
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    bits_left <= BITS_REG)
    else $error("bit counter out of range");

  // An idle engine keeps its clock low.
  a_idle_clock: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !clock_level)
    else $error("clock high while idle");

  // Without an input transfer the engine does not move.
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> ($stable(busy) && $stable(bits_left) && $stable(tick_count)))
    else $error("engine advanced without an input transfer");
`endif

endmodule

`default_nettype wire
